>>> sv/ats_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the adaptive tension smoother
// Field widths, register codes, fixed-point constants and the fifth-root
// table generator used at elaboration.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CH_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING = 1'b0,
    CFG_TENSION   = 1'b1
  } cfg_reg_e;

  localparam logic [VAL_W-1:0]        SMOOTH_RESET = 16'd32768;
  localparam logic signed [VAL_W-1:0] TENSION_RESET = 16'sd0;
  localparam logic signed [VAL_W-1:0] TENSION_HALF  = 16'sd16384;
  localparam logic [VAL_W-1:0]        VAL_MAX       = 16'hFFFF;
  localparam logic [32:0]             ROUND_HALF    = 33'd32768;

  // floor(n/3) == (n * DIV3_RECIP) >> DIV3_SHIFT for every n below 2^19
  localparam logic [17:0] DIV3_RECIP = 18'd174763;
  localparam int unsigned DIV3_SHIFT = 19;

  // v^5 in Q0.32, each product truncated as in the fixed-point spec
  function automatic longint unsigned fifth_power_q32(longint unsigned v);
    longint unsigned p;
    p = v * v;
    p = (p * v) >> 16;
    p = (p * v) >> 16;
    p = (p * v) >> 16;
    return p;
  endfunction

  // Largest v in 0..65536 with v^5 * entries <= k << 32 (bitwise search).
  function automatic logic [16:0] root_entry(int unsigned k, int unsigned entries);
    longint unsigned lim;
    longint unsigned v;
    longint unsigned cand;
    lim = longint'(k) << 32;
    v   = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = v | (64'd1 << b);
      if (cand <= 64'd65536 && fifth_power_q32(cand) * longint'(entries) <= lim) begin
        v = cand;
      end
    end
    return v[16:0];
  endfunction

endpackage

>>> sv/ats_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ats_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/adaptive_tension_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_tension_smoother: per-channel one-pole smoother, adaptive coefficient
// Keeps the last output of each channel in a RAM and a seen flag per channel;
// the coefficient moves toward 0 or toward ~1 with the jump size, driven by the
// tension register. All products go through one shared 18x18 multiplier.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------------
//  in       | in  | in_valid_i / in_stall_o    | channel_index_i, sample_value_i,
//           |     |                            | sample_invalid_i, restart_i
//  out      | out | out_valid_o / out_stall_i  | out_channel_o, smoothed_value_o
//  cfg      | in  | cfg_we_i (no back-pressure)| cfg_index_i, cfg_wdata_i
//
//  Pass-through (first sample, restart, invalid, channel out of range) skips
//  the arithmetic; zero tension goes straight to the mix, tension above one
//  half skips the table index and lookup, any other tension runs them all.
//  Every product goes in turn to the single shared multiplier, one per cycle.
//  One item in the sequencer at a time: in_stall_o is high while it runs and
//  while its finished result waits for the output register. A result held in
//  the output register does not block the next transaction.
//  Reset clears the seen flags, so the RAM needs no clearing pass; the
//  configuration registers return to smoothing 0.5, tension 0.
//
module adaptive_tension_smoother #(
  parameter int unsigned CHANNELS           = 64,
  parameter int unsigned ROOT_TABLE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ats_pkg::CH_W-1:0]            channel_index_i,
  input  logic [ats_pkg::VAL_W-1:0]           sample_value_i,
  input  logic                                sample_invalid_i,
  input  logic                                restart_i,
  // result transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ats_pkg::CH_W-1:0]            out_channel_o,
  output logic [ats_pkg::VAL_W-1:0]           smoothed_value_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ats_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ats_pkg::VAL_W-1:0]           cfg_wdata_i
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW = $clog2(ROOT_TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an input transaction
    S_READ,   // RAM data back, pass-through or start of arithmetic
    S_IDX_M,  // m = 4d/3 via reciprocal
    S_IDX_I,  // m * entries
    S_ROOT,   // round to table index
    S_LOOK,   // table read
    S_STEP,   // step * r
    S_COEF,   // s * a or (1-s) * a
    S_ADJ,    // coefficient update
    S_MIX0,   // coef * prev
    S_MIX1,   // (1-coef) * x
    S_SUM     // round, saturate, write back
  } state_e;

  state_e state_q;

  // configuration
  logic [ats_pkg::VAL_W-1:0]        smooth_q;
  logic signed [ats_pkg::VAL_W-1:0] tension_q;

  // control
  logic                out_valid_q;
  logic                res_pend_q;   // finished result waiting for the output register
  logic [CHANNELS-1:0] seen_q;

  // output register
  logic [ats_pkg::CH_W-1:0]  out_ch_q;
  logic [ats_pkg::VAL_W-1:0] out_y_q;

  // datapath
  logic [ats_pkg::CH_W-1:0]  ch_q;
  logic [ats_pkg::VAL_W-1:0] x_q;
  logic                      inv_q;
  logic                      rst_q;
  logic                      inr_q;
  logic [ats_pkg::VAL_W-1:0] prev_q;
  logic [ats_pkg::VAL_W-1:0] step_q;
  logic [16:0]               r_q;
  logic [IW-1:0]             idx_q;
  logic [ats_pkg::VAL_W-1:0] coef_q;
  logic [31:0]               acc_q;
  logic [35:0]               prod_q;
  logic [ats_pkg::VAL_W-1:0] y_q;

  // fifth-root table, built at elaboration
  logic [16:0] root_tab [ROOT_TABLE_ENTRIES + 1];
  for (genvar k = 0; k <= ROOT_TABLE_ENTRIES; k++) begin : g_root
    assign root_tab[k] = ats_pkg::root_entry(k, ROOT_TABLE_ENTRIES);
  end

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic                      in_accept;
  logic                      out_load;
  logic                      in_range;
  logic [AW+5:0]             in_ch_ext;
  logic [AW+5:0]             ch_ext;
  logic [AW-1:0]             in_addr;
  logic [AW-1:0]             addr_q;
  logic [ats_pkg::VAL_W-1:0] ram_rdata;
  logic                      ram_we;
  logic [ats_pkg::VAL_W-1:0] ram_wdata;
  logic                      pass;
  logic [ats_pkg::VAL_W-1:0] pass_y;
  logic [ats_pkg::VAL_W-1:0] step_d;
  logic                      t_upper;
  logic                      t_zero;
  logic signed [16:0]        t_dist;
  logic [17:0]               t_dist4;
  logic [ats_pkg::VAL_W-1:0] t_off;
  logic [16:0]               r_up;
  logic [32:0]               idx_sum;
  logic [16:0]               idx_wide;
  logic [32:0]               mix_sum;
  logic [16:0]               y_wide;
  logic [ats_pkg::VAL_W-1:0] sum_y;
  logic [17:0]               mul_a;
  logic [17:0]               mul_b;

  assign in_stall_o = (state_q != S_IDLE) || res_pend_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(channel_index_i) < CHANNELS);
  // pending result moves out once the output register is empty or being taken
  assign out_load   = res_pend_q && (!out_valid_q || !out_stall_i);

  // channel -> RAM address, zero-extended or truncated to the RAM depth
  assign in_ch_ext = {{AW{1'b0}}, channel_index_i};
  assign ch_ext    = {{AW{1'b0}}, ch_q};
  assign in_addr   = in_ch_ext[AW-1:0];
  assign addr_q    = ch_ext[AW-1:0];

  assign pass   = !inr_q || inv_q || rst_q || !seen_q[addr_q];
  assign pass_y = inv_q ? '0 : x_q;
  assign step_d = (ram_rdata > x_q) ? (ram_rdata - x_q) : (x_q - ram_rdata);

  assign t_upper = (tension_q > ats_pkg::TENSION_HALF);
  assign t_zero  = (tension_q == ats_pkg::TENSION_RESET);
  // lower branch: d = 0.5 - t, in 0..49152
  assign t_dist  = 17'sd16384 - 17'(tension_q);
  assign t_dist4 = {t_dist[15:0], 2'b00};
  // upper branch: r = 2*(t - 0.5)
  assign t_off   = 16'(tension_q) - 16'(ats_pkg::TENSION_HALF);
  assign r_up    = {1'b0, t_off[14:0], 1'b0};

  assign idx_sum  = {1'b0, prod_q[31:0]} + ats_pkg::ROUND_HALF;
  assign idx_wide = idx_sum[32:16];

  assign mix_sum = {1'b0, acc_q} + {1'b0, prod_q[31:0]} + ats_pkg::ROUND_HALF;
  assign y_wide  = mix_sum[32:16];
  assign sum_y   = (y_wide > {1'b0, ats_pkg::VAL_MAX}) ? ats_pkg::VAL_MAX : y_wide[15:0];

  assign ram_we    = ((state_q == S_READ) && pass && inr_q) || (state_q == S_SUM);
  assign ram_wdata = (state_q == S_READ) ? pass_y : sum_y;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDX_M: begin
        mul_a = t_dist4;
        mul_b = ats_pkg::DIV3_RECIP;
      end
      S_IDX_I: begin
        mul_a = {1'b0, prod_q[35:ats_pkg::DIV3_SHIFT]};
        mul_b = 18'(ROOT_TABLE_ENTRIES);
      end
      S_STEP: begin
        mul_a = {2'b00, step_q};
        mul_b = {1'b0, r_q};
      end
      S_COEF: begin
        mul_a = t_upper ? {2'b00, smooth_q} : {2'b00, ~smooth_q};
        mul_b = {2'b00, prod_q[31:16]};
      end
      S_MIX0: begin
        mul_a = {2'b00, coef_q};
        mul_b = {2'b00, prev_q};
      end
      S_MIX1: begin
        mul_a = {1'b0, 17'h10000 - {1'b0, coef_q}};
        mul_b = {2'b00, x_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // last-output store
  // --------------------------------------------------------------------------
  ats_ram #(
    .WIDTH (ats_pkg::VAL_W),
    .DEPTH (CHANNELS)
  ) u_last (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // sequencer, seen flags, configuration, output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      res_pend_q  <= 1'b0;
      out_ch_q    <= '0;
      out_y_q     <= '0;
      seen_q      <= '0;
      smooth_q    <= ats_pkg::SMOOTH_RESET;
      tension_q   <= ats_pkg::TENSION_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (ats_pkg::cfg_reg_e'(cfg_index_i))
          ats_pkg::CFG_SMOOTHING: smooth_q  <= cfg_wdata_i;
          ats_pkg::CFG_TENSION:   tension_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_ch_q    <= ch_q;
        out_y_q     <= y_q;
        res_pend_q  <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // res_pend_q is low whenever the sequencer runs, so the sets below
      // never meet the clear above
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (inr_q) begin
            seen_q[addr_q] <= 1'b1;
          end
          if (pass) begin
            state_q    <= S_IDLE;
            res_pend_q <= 1'b1;
          end else if (t_zero) begin
            state_q <= S_MIX0;
          end else if (t_upper) begin
            state_q <= S_STEP;
          end else begin
            state_q <= S_IDX_M;
          end
        end
        S_IDX_M: state_q <= S_IDX_I;
        S_IDX_I: state_q <= S_ROOT;
        S_ROOT:  state_q <= S_LOOK;
        S_LOOK:  state_q <= S_STEP;
        S_STEP:  state_q <= S_COEF;
        S_COEF:  state_q <= S_ADJ;
        S_ADJ:   state_q <= S_MIX0;
        S_MIX0:  state_q <= S_MIX1;
        S_MIX1:  state_q <= S_SUM;
        S_SUM: begin
          state_q    <= S_IDLE;
          res_pend_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= 36'(mul_a) * 36'(mul_b);
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ch_q  <= channel_index_i;
          x_q   <= sample_value_i;
          inv_q <= sample_invalid_i;
          rst_q <= restart_i;
          inr_q <= in_range;
        end
      end
      S_READ: begin
        prev_q <= ram_rdata;
        step_q <= step_d;
        y_q    <= pass_y;
        coef_q <= smooth_q;
        r_q    <= r_up;
      end
      S_ROOT: begin
        // never above the table end, clamp kept for safety
        idx_q <= (idx_wide > 17'(ROOT_TABLE_ENTRIES)) ? IW'(ROOT_TABLE_ENTRIES)
                                                       : idx_wide[IW-1:0];
      end
      S_LOOK: r_q <= root_tab[idx_q];
      S_ADJ: begin
        coef_q <= t_upper ? (smooth_q - prod_q[31:16]) : (smooth_q + prod_q[31:16]);
      end
      S_MIX1: acc_q <= prod_q[31:0];
      S_SUM:  y_q   <= sum_y;
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_ch_q;
  assign smoothed_value_o = out_y_q;

endmodule

>>> verif/ats_smoothing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_smoothing_checker: prediction and comparison for the tension smoother
// Watches the input, result and register ports, predicts each smoothed level
// from its own copy of the channel memory and registers, and compares results
// in order.
// ----------------------------------------------------------------------------
module ats_smoothing_checker #(
  parameter int unsigned CHANNELS           = 64,
  parameter int unsigned ROOT_TABLE_ENTRIES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [ats_pkg::CH_W-1:0]      channel_index_i,
  input  logic [ats_pkg::VAL_W-1:0]     sample_value_i,
  input  logic                          sample_invalid_i,
  input  logic                          restart_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [ats_pkg::CH_W-1:0]      out_channel_i,
  input  logic [ats_pkg::VAL_W-1:0]     smoothed_value_i,
  input  logic                          cfg_we_i,
  input  logic [ats_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ats_pkg::VAL_W-1:0]     cfg_wdata_i,
  output int                            pending_o,
  output int                            checked_o,
  output int                            mismatches_o
);

  typedef struct packed {
    logic [ats_pkg::CH_W-1:0]  chan;
    logic [ats_pkg::VAL_W-1:0] level;
  } smoothed_t;

  smoothed_t                        expected_levels[$];
  smoothed_t                        want_res;
  logic [ats_pkg::VAL_W-1:0]        last_level [CHANNELS];
  logic                             seen_flag [CHANNELS];
  logic [ats_pkg::VAL_W-1:0]        smooth_coef;
  logic signed [ats_pkg::VAL_W-1:0] tension_q;
  logic [ats_pkg::VAL_W:0]          fifth_root_lut [0:ROOT_TABLE_ENTRIES];
  logic [ats_pkg::VAL_W-1:0]        next_level;
  int                               mismatches;
  int                               checked;

  assign mismatches_o = mismatches;
  assign checked_o    = checked;

  // v^5 in Q0.32, truncating after every product
  function automatic longint unsigned pow5_q32(longint unsigned v);
    longint unsigned p;
    p = v * v;
    repeat (3) p = (p * v) >> 16;
    return p;
  endfunction

  // largest root per table slot, found by bisection
  initial begin
    longint unsigned lo, hi, mid, lim;
    for (int k = 0; k <= ROOT_TABLE_ENTRIES; k++) begin
      lo  = 0;
      hi  = 65536;
      lim = longint'(k) << 32;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5_q32(mid) * ROOT_TABLE_ENTRIES <= lim) lo = mid;
        else hi = mid - 1;
      end
      fifth_root_lut[k] = lo[ats_pkg::VAL_W:0];
    end
  end

  function automatic logic [ats_pkg::VAL_W-1:0] blend_level(
      logic [ats_pkg::VAL_W-1:0] prev, logic [ats_pkg::VAL_W-1:0] x);
    longint unsigned s, jump, coef, r, adj, m, idx, y;
    int t;
    s    = smooth_coef;
    t    = tension_q;
    jump = (prev > x) ? prev - x : x - prev;
    coef = s;
    if (t > 16384) begin
      // pull toward zero
      r    = longint'(t - 16384) * 2;
      adj  = (jump * r) >> 16;
      coef = s - ((s * adj) >> 16);
    end else if (t != 0) begin
      // push toward nearly one through the fifth-root table
      m   = (longint'(16384 - t) * 65536) / 49152;
      idx = (m * ROOT_TABLE_ENTRIES + 32768) >> 16;
      if (idx > ROOT_TABLE_ENTRIES) idx = ROOT_TABLE_ENTRIES;
      r    = fifth_root_lut[idx];
      adj  = (jump * r) >> 16;
      coef = s + (((65535 - s) * adj) >> 16);
    end
    if (coef > 65535) coef = 65535;
    y = (coef * prev + (65536 - coef) * x + 32768) >> 16;
    if (y > 65535) y = 65535;
    return y[ats_pkg::VAL_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns checker: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_levels.delete();
      for (int c = 0; c < CHANNELS; c++) begin
        last_level[c] = '0;
        seen_flag[c]  = 1'b0;
      end
      smooth_coef = ats_pkg::SMOOTH_RESET;
      tension_q   = ats_pkg::TENSION_RESET;
      mismatches  = 0;
      checked     = 0;
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          flag_mismatch("result with nothing expected, level", smoothed_value_i, -1);
        end else begin
          want_res = expected_levels.pop_front();
          if (out_channel_i !== want_res.chan)
            flag_mismatch("out_channel", out_channel_i, want_res.chan);
          if (smoothed_value_i !== want_res.level)
            flag_mismatch("smoothed_value", smoothed_value_i, want_res.level);
          checked++;
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (channel_index_i >= CHANNELS) begin
          next_level = sample_invalid_i ? '0 : sample_value_i;
        end else if (sample_invalid_i) begin
          next_level = '0;
          seen_flag[channel_index_i]  = 1'b1;
          last_level[channel_index_i] = '0;
        end else if (restart_i || !seen_flag[channel_index_i]) begin
          next_level = sample_value_i;
          seen_flag[channel_index_i]  = 1'b1;
          last_level[channel_index_i] = next_level;
        end else begin
          next_level = blend_level(last_level[channel_index_i], sample_value_i);
          last_level[channel_index_i] = next_level;
        end
        expected_levels.push_back('{chan: channel_index_i, level: next_level});
      end

      if (cfg_we_i) begin
        case (ats_pkg::cfg_reg_e'(cfg_index_i))
          ats_pkg::CFG_SMOOTHING: smooth_coef = cfg_wdata_i;
          ats_pkg::CFG_TENSION:   tension_q   = cfg_wdata_i;
          default: ;
        endcase
      end

      pending_o <= expected_levels.size();
    end
  end

endmodule

>>> verif/adaptive_tension_smoother_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_tension_smoother_tb: top-level testbench of the tension smoother
// Drives sample transactions and register settings through nine phases with
// varying back-pressure; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module adaptive_tension_smoother_tb;

  localparam int unsigned N_CHANNELS   = 64;
  localparam int unsigned N_ROOTS      = 256;
  localparam int          N_SETTINGS   = 9;
  localparam int          RANDOM_PER   = 66;   // random samples per setting
  localparam int          HOLD_CYCLES  = 150;  // long output hold-off
  localparam int          TAIL_CYCLES  = 30;   // well past the slowest latency

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_stall;
  logic [ats_pkg::CH_W-1:0]      channel_index;
  logic [ats_pkg::VAL_W-1:0]     sample_value;
  logic                          sample_invalid;
  logic                          restart;
  logic                          out_valid;
  logic                          out_stall;
  logic [ats_pkg::CH_W-1:0]      out_channel;
  logic [ats_pkg::VAL_W-1:0]     smoothed_value;
  logic                          cfg_we;
  logic [ats_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ats_pkg::VAL_W-1:0]     cfg_wdata;

  int pending;
  int checked;
  int mismatches;

  // back-pressure knobs, percent of cycles spent idle
  int send_idle_pct;
  int recv_idle_pct;
  // hold-off requests: the stimulus bumps the ask count, the receiver serves it
  int hold_asked;
  int hold_served;
  int hold_left;
  int items_sent;

  logic [ats_pkg::VAL_W-1:0] smooth_set  [N_SETTINGS];
  logic [ats_pkg::VAL_W-1:0] tension_set [N_SETTINGS];

  adaptive_tension_smoother #(
    .CHANNELS           (N_CHANNELS),
    .ROOT_TABLE_ENTRIES (N_ROOTS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .channel_index_i  (channel_index),
    .sample_value_i   (sample_value),
    .sample_invalid_i (sample_invalid),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_channel_o    (out_channel),
    .smoothed_value_o (smoothed_value),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata)
  );

  ats_smoothing_checker #(
    .CHANNELS           (N_CHANNELS),
    .ROOT_TABLE_ENTRIES (N_ROOTS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .channel_index_i  (channel_index),
    .sample_value_i   (sample_value),
    .sample_invalid_i (sample_invalid),
    .restart_i        (restart),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_channel_i    (out_channel),
    .smoothed_value_i (smoothed_value),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .pending_o        (pending),
    .checked_o        (checked),
    .mismatches_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous cap; a correct run needs a small fraction of this.
  initial begin
    #3ms;
    $display("timeout with %0d results outstanding", pending);
    $display("adaptive_tension_smoother_tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is asked for.
  initial begin
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asked) begin
        hold_left   = HOLD_CYCLES;
        hold_served = hold_asked;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One sample transaction. Called and returning at a falling edge; valid stays
  // high on return so back-to-back transactions need no second assignment.
  task automatic send_sample(input logic [ats_pkg::CH_W-1:0] ch,
                             input logic [ats_pkg::VAL_W-1:0] x,
                             input logic inv, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    channel_index  <= ch;
    sample_value   <= x;
    sample_invalid <= inv;
    restart        <= rs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Mostly a handful of busy channels so history builds up; the rest anywhere.
  // Samples lean on the rails to give large jumps.
  task automatic send_random_sample();
    logic [ats_pkg::CH_W-1:0]  ch;
    logic [ats_pkg::VAL_W-1:0] x;
    int                        pick;
    ch   = ($urandom_range(99) < 70) ? 6'($urandom_range(7))
                                     : 6'($urandom_range(N_CHANNELS - 1));
    pick = $urandom_range(99);
    if (pick < 15)      x = '0;
    else if (pick < 30) x = ats_pkg::VAL_MAX;
    else                x = 16'($urandom_range(16'hFFFF));
    send_sample(ch, x, $urandom_range(99) < 6, $urandom_range(99) < 6);
  endtask

  // Sender pause: drop valid and let every outstanding result drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Both registers in back-to-back cycles; only while the block is idle.
  task automatic write_settings(input logic [ats_pkg::VAL_W-1:0] smooth,
                                input logic [ats_pkg::VAL_W-1:0] tens);
    cfg_we    <= 1'b1;
    cfg_index <= ats_pkg::CFG_SMOOTHING;
    cfg_wdata <= smooth;
    @(negedge clk_i);
    cfg_index <= ats_pkg::CFG_TENSION;
    cfg_wdata <= tens;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    channel_index  = '0;
    sample_value   = '0;
    sample_invalid = 1'b0;
    restart        = 1'b0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ats_pkg::CFG_SMOOTHING;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_asked     = 0;
    items_sent     = 0;

    // Setting 0 is the reset state. Then: both rails of each register,
    // tension just above and exactly at one half, the smallest tensions
    // either side of zero, and two random settings.
    smooth_set[0] = ats_pkg::SMOOTH_RESET;  tension_set[0] = ats_pkg::TENSION_RESET;
    smooth_set[1] = 16'hFFFF;      tension_set[1] = 16'h7FFF;   // +max tension
    smooth_set[2] = 16'h0000;      tension_set[2] = 16'h8000;   // -1.0
    smooth_set[3] = 16'd49152;     tension_set[3] = ats_pkg::TENSION_HALF;
    smooth_set[4] = 16'd20000;     tension_set[4] = 16'd16385;  // just above half
    smooth_set[5] = 16'hFFFF;      tension_set[5] = 16'hFFFF;   // -1 lsb
    smooth_set[6] = 16'd1;         tension_set[6] = 16'd1;      // +1 lsb
    for (int i = 7; i < N_SETTINGS; i++) begin
      smooth_set[i]  = 16'($urandom_range(16'hFFFF));
      tension_set[i] = 16'($urandom_range(16'hFFFF));
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      // receiver-heavy idling, then sender-heavy, then flat out
      if (ph < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 63;
      end else if (ph < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph > 0) begin
        wait_drained();
        write_settings(smooth_set[ph], tension_set[ph]);
      end

      if (ph == 0) begin
        // first sample passes, then a full-scale jump with the default coefficient
        send_sample(6'd0, 16'h0000, 1'b0, 1'b0);
        send_sample(6'd0, 16'hFFFF, 1'b0, 1'b0);
        // invalid sample clears history to zero but marks the channel seen
        send_sample(6'd0, 16'hFFFF, 1'b1, 1'b0);
        send_sample(6'd0, 16'hFFFF, 1'b0, 1'b0);
        // restart passes through; restart with invalid still gives zero
        send_sample(6'd0, 16'h04D2, 1'b0, 1'b1);
        send_sample(6'd0, 16'h01F4, 1'b1, 1'b1);
        // top channel: first sample, then no jump at all
        send_sample(6'd63, 16'hFFFF, 1'b0, 1'b0);
        send_sample(6'd63, 16'hFFFF, 1'b0, 1'b0);
        // invalid as the very first sample of a channel
        send_sample(6'd42, 16'hAAAA, 1'b1, 1'b0);
      end else if (ph <= 6) begin
        // full-range jump under this setting, from a known starting level
        send_sample(6'd1, 16'h0000, 1'b0, 1'b1);
        send_sample(6'd1, 16'hFFFF, 1'b0, 1'b0);
      end

      for (int n = 0; n < RANDOM_PER; n++) begin
        // One long output hold-off while samples keep coming: the block
        // fills, stalls its input, and the sender has to sit on its offer.
        if (ph == 4 && n == 20) begin
          hold_asked++;
          send_idle_pct = 0;
        end
        if (ph == 4 && n == 40) send_idle_pct = 63;
        send_random_sample();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d sample transactions over %0d register settings, %0d results checked",
             items_sent, N_SETTINGS, checked);
    $display("back-pressure on each side in turn, one long output hold-off, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("adaptive_tension_smoother_tb: PASS");
    end else begin
      $display("adaptive_tension_smoother_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> adaptive_tension_smoother.f
sv/ats_pkg.sv
sv/ats_ram.sv
sv/adaptive_tension_smoother.sv
verif/ats_smoothing_checker.sv
verif/adaptive_tension_smoother_tb.sv
